// File: rtl/mrr_pkg.sv
// ============================================================================
// mrr_pkg
// Shared types and constants for the Miller-Rabin round block.
// ============================================================================
package mrr_pkg;

  // Operand width; candidate and witness are masked to this many bits (8..64).
  localparam int NUM_BITS   = 64;
  localparam int CNT_BITS   = $clog2(NUM_BITS + 1);

  typedef logic [NUM_BITS-1:0] operand_t;

  typedef struct packed {
    logic [63:0] candidate;
    logic [63:0] witness;
  } mrr_in_t;

  typedef struct packed {
    logic probable_prime;
    logic decided_trivially;
  } mrr_out_t;

  // Request to the serial modular multiplier.
  typedef struct packed {
    logic     start;
    operand_t x;
    operand_t y;
    operand_t m;
  } mrr_mul_req_t;

  // Response from the serial modular multiplier.
  typedef struct packed {
    logic     busy;
    logic     done;
    operand_t result;
  } mrr_mul_rsp_t;

endpackage

// File: rtl/mrr_mulmod.sv
// ============================================================================
// mrr_mulmod
// Bit-serial modular multiplier: (x * y) mod m, one modular add per cycle.
// ============================================================================
module mrr_mulmod (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mrr_pkg::mrr_mul_req_t req_i,
  output mrr_pkg::mrr_mul_rsp_t rsp_o
);
  import mrr_pkg::*;

  operand_t            acc_q, acc_d;
  operand_t            y_q, y_d;
  operand_t            x_q, m_q;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                phase_q, phase_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;

  logic [NUM_BITS:0] sum, diff;
  operand_t          addend;

  // Modular add of acc and either acc (double) or x (add phase).
  assign addend = phase_q ? x_q : acc_q;
  assign sum    = {1'b0, acc_q} + {1'b0, addend};
  assign diff   = sum - {1'b0, m_q};

  always_comb begin
    acc_d   = acc_q;
    y_d     = y_q;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      acc_d   = '0;
      y_d     = req_i.y;
      cnt_d   = CNT_BITS'(NUM_BITS);
      phase_d = 1'b0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      acc_d = (sum >= {1'b0, m_q}) ? diff[NUM_BITS-1:0] : sum[NUM_BITS-1:0];
      if (!phase_q && y_q[NUM_BITS-1]) begin
        phase_d = 1'b1;
      end else begin
        phase_d = 1'b0;
        y_d     = {y_q[NUM_BITS-2:0], 1'b0};
        cnt_d   = cnt_q - 1'b1;
        if (cnt_q == CNT_BITS'(1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    y_q   <= y_d;
    if (req_i.start) begin
      x_q <= req_i.x;
      m_q <= req_i.m;
    end
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

endmodule

// File: rtl/miller_rabin_round.sv
// ============================================================================
// miller_rabin_round
// One Miller-Rabin round on a candidate with a supplied witness.
// ============================================================================
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  in      | input     | in_valid_i / in_ready_o | in_data_i  (mrr_in_t)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (mrr_out_t)
//
//  One item at a time. For candidates up to 4 the result is decided when
//  the item is accepted and is loaded into the output register from S_DONE
//  once that register is free. Otherwise the time is set by the bit-serial
//  multiplier: one reduction, up to 2*NUM_BITS-1 products in the power loop
//  and up to NUM_BITS-1 squarings (at most 2*NUM_BITS products in all), plus
//  the trailing-zero strip of n-1 in S_TZ and the sequencer steps.
//  Reset clears the sequencer and output valid; no clearing pass.
//  A result waiting on out_ready_i does not block the next beat on in.
//
module miller_rabin_round (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mrr_pkg::mrr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mrr_pkg::mrr_out_t out_data_o
);
  import mrr_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TZ   = 4'd1;  // strip trailing zeros of n-1
  localparam logic [3:0] S_RED  = 4'd2;  // b = a mod n
  localparam logic [3:0] S_PMUL = 4'd3;  // r = r*b if exponent bit set
  localparam logic [3:0] S_PSQR = 4'd4;  // b = b*b, advance exponent
  localparam logic [3:0] S_CHK  = 4'd5;  // first test of x
  localparam logic [3:0] S_SQ   = 4'd6;  // x = x*x
  localparam logic [3:0] S_SQC  = 4'd7;  // test after a squaring
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]          state_q, state_d;
  operand_t            n_q, n_d, nm1_q, nm1_d, a_q, a_d;
  operand_t            e_q, e_d, b_q, b_d, r_q, r_d;
  logic [CNT_BITS-1:0] s_q, s_d;
  logic                pend_q, pend_d;
  mrr_out_t            res_q, res_d;
  logic                out_valid_q, out_valid_d;
  mrr_out_t            out_q, out_d;

  mrr_mul_req_t mul_req;
  mrr_mul_rsp_t mul_rsp;
  logic         mul_start;

  operand_t n_in, a_in;
  assign n_in = in_data_i.candidate[NUM_BITS-1:0];
  assign a_in = in_data_i.witness[NUM_BITS-1:0];

  logic in_fire, out_fire;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  mrr_mulmod u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Operand select for the shared multiplier.
  always_comb begin
    mul_req.start = mul_start;
    mul_req.m     = n_q;
    unique case (state_q)
      S_RED: begin
        mul_req.x = operand_t'(1);
        mul_req.y = a_q;
      end
      S_PMUL: begin
        mul_req.x = r_q;
        mul_req.y = b_q;
      end
      S_PSQR: begin
        mul_req.x = b_q;
        mul_req.y = b_q;
      end
      default: begin
        mul_req.x = r_q;
        mul_req.y = r_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    nm1_d       = nm1_q;
    a_d         = a_q;
    e_d         = e_q;
    b_d         = b_q;
    r_d         = r_q;
    s_d         = s_q;
    pend_d      = pend_q;
    res_d       = res_q;
    mul_start   = 1'b0;
    out_valid_d = out_valid_q && !out_fire;
    out_d       = out_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          n_d   = n_in;
          a_d   = a_in;
          nm1_d = n_in - 1'b1;
          e_d   = n_in - 1'b1;
          s_d   = '0;
          if (n_in <= operand_t'(4)) begin
            res_d.probable_prime    = (n_in == operand_t'(2)) ||
                                      (n_in == operand_t'(3));
            res_d.decided_trivially = 1'b1;
            state_d = S_DONE;
          end else begin
            res_d.probable_prime    = 1'b0;
            res_d.decided_trivially = 1'b0;
            state_d = S_TZ;
          end
        end
      end
      S_TZ: begin
        if (!e_q[0]) begin
          e_d = {1'b0, e_q[NUM_BITS-1:1]};
          s_d = s_q + 1'b1;
        end else begin
          state_d = S_RED;
        end
      end
      S_RED: begin
        mul_start = !pend_q;
        pend_d    = 1'b1;
        if (mul_rsp.done) begin
          pend_d  = 1'b0;
          b_d     = mul_rsp.result;
          r_d     = operand_t'(1);
          state_d = S_PMUL;
        end
      end
      S_PMUL: begin
        if (!e_q[0]) begin
          state_d = S_PSQR;
        end else begin
          mul_start = !pend_q;
          pend_d    = 1'b1;
          if (mul_rsp.done) begin
            pend_d  = 1'b0;
            r_d     = mul_rsp.result;
            state_d = S_PSQR;
          end
        end
      end
      S_PSQR: begin
        // Skip the final squaring of b: its value is never used.
        if (e_q[NUM_BITS-1:1] == '0) begin
          state_d = S_CHK;
        end else begin
          mul_start = !pend_q;
          pend_d    = 1'b1;
          if (mul_rsp.done) begin
            pend_d  = 1'b0;
            b_d     = mul_rsp.result;
            e_d     = {1'b0, e_q[NUM_BITS-1:1]};
            state_d = S_PMUL;
          end
        end
      end
      S_CHK: begin
        if (r_q == operand_t'(1) || r_q == nm1_q) begin
          res_d.probable_prime = 1'b1;
          state_d = S_DONE;
        end else if (s_q == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        mul_start = !pend_q;
        pend_d    = 1'b1;
        if (mul_rsp.done) begin
          pend_d  = 1'b0;
          r_d     = mul_rsp.result;
          s_d     = s_q - 1'b1;
          state_d = S_SQC;
        end
      end
      S_SQC: begin
        priority if (r_q == nm1_q) begin
          res_d.probable_prime = 1'b1;
          state_d = S_DONE;
        end else if (r_q == operand_t'(1) || s_q == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_SQ;
        end
      end
      S_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || out_fire) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    nm1_q <= nm1_d;
    a_q   <= a_d;
    e_q   <= e_d;
    b_q   <= b_d;
    r_q   <= r_d;
    s_q   <= s_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // A product only completes for a request this sequencer is waiting on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> pend_q)
    else $error("multiplier done without pending request");

  // An accepted beat closes the input until the result is queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("input accepted while busy");

  // No multiplier activity while idle or handing off a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_DONE) |-> (!mul_rsp.busy && !pend_q))
    else $error("multiplier busy outside compute states");
`endif

endmodule

// File: test/miller_rabin_round_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// miller_rabin_round_tb
// Self-checking bench for one Miller-Rabin round. A directed table covers
// small candidates, extreme witnesses, even candidates and known primes.
// Random candidates and witnesses follow, including products of two random
// odd numbers and candidates near the top of the range. Every result beat
// is compared with a table answer or a local modular-arithmetic predictor.
// ============================================================================
module miller_rabin_round_tb;
  import mrr_pkg::*;

  localparam int        NUM_RANDOM = 80;
  localparam longint    CYCLE_LIMIT = 64'd10000000;
  localparam logic [63:0] ALL_ONES = '1;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  mrr_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  mrr_out_t out_data_o;

  // One row of the directed table. has_answer marks rows whose answer is
  // obvious; the rest go to the predictor.
  typedef struct {
    logic [63:0] cand;
    logic [63:0] wit;
    logic        has_answer;
    mrr_out_t    answer;
  } round_row_t;

  mrr_out_t verdict_q[$];
  int       error_count = 0;
  longint   cycle_count = 0;
  bit       calm_tail = 1'b0;

  miller_rabin_round u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Exact (x * y) mod m on a 128-bit product.
  function automatic logic [63:0] mulmod(logic [63:0] x, logic [63:0] y,
                                         logic [63:0] m);
    logic [127:0] prod;
    prod = {64'd0, x} * {64'd0, y};
    return 64'((prod % {64'd0, m}));
  endfunction

  // Predict the verdict of one round.
  function automatic mrr_out_t predict_round(logic [63:0] cand, logic [63:0] wit);
    mrr_out_t    v;
    logic [63:0] n, a, d, x, r, nm1;
    int          s;
    n = cand & (ALL_ONES >> (64 - NUM_BITS));
    a = wit & (ALL_ONES >> (64 - NUM_BITS));
    v = '0;
    if (n <= 64'd4) begin
      v.probable_prime = (n == 64'd2) || (n == 64'd3);
      v.decided_trivially = 1'b1;
      return v;
    end
    nm1 = n - 64'd1;
    d = nm1;
    s = 0;
    while (d[0] == 1'b0) begin
      d = d >> 1;
      s++;
    end
    // square-and-multiply on the reduced witness
    x = a % n;
    r = 64'd1;
    while (d != 0) begin
      if (d[0]) r = mulmod(r, x, n);
      x = mulmod(x, x, n);
      d = d >> 1;
    end
    if (r == 64'd1 || r == nm1) begin
      v.probable_prime = 1'b1;
    end else begin
      for (int i = 0; i < s; i++) begin
        r = mulmod(r, r, n);
        if (r == 64'd1) break;
        if (r == nm1) begin
          v.probable_prime = 1'b1;
          break;
        end
      end
    end
    return v;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Drop valid for an idle burst if one is drawn, then present the beat and
  // hold it until taken. Valid stays high afterwards; the caller drops it.
  task automatic send_beat(logic [63:0] cand, logic [63:0] wit, mrr_out_t verdict);
    int gap;
    if (!calm_tail && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{candidate: cand, witness: wit};
    do @(posedge clk_i); while (!in_ready_o);
    verdict_q = {verdict_q, verdict};
  endtask

  // Receiver: stall in random bursts, check every result beat.
  initial begin : receive_side
    mrr_out_t want;
    int       stall;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result beat %b", $time, out_data_o);
          error_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_data_o.probable_prime !== want.probable_prime) begin
            $display("%0t: probable_prime expected %b actual %b", $time,
                     want.probable_prime, out_data_o.probable_prime);
            error_count++;
          end
          if (out_data_o.decided_trivially !== want.decided_trivially) begin
            $display("%0t: decided_trivially expected %b actual %b", $time,
                     want.decided_trivially, out_data_o.decided_trivially);
            error_count++;
          end
        end
      end
      if (!calm_tail && out_ready_i && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 15);
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
        // beats cannot be taken while ready is low, so skip the check here
      end
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog on total cycles.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : send_side
    round_row_t  rows [20];
    logic [63:0] cand, wit, p, q;
    mrr_out_t    ans;
    int          pick, wait_cycles;
    rows = '{
      // small candidates are decided without the witness
      '{64'd0, ALL_ONES, 1'b1, 2'b01},
      '{64'd1, 64'd0, 1'b1, 2'b01},
      '{64'd2, 64'd5, 1'b1, 2'b11},
      '{64'd3, ALL_ONES, 1'b1, 2'b11},
      '{64'd4, 64'd2, 1'b1, 2'b01},
      // witness a multiple of the candidate fails, witness one mod n passes
      '{64'd7, 64'd0, 1'b1, 2'b00},
      '{64'd7, 64'd14, 1'b1, 2'b00},
      '{64'd7, 64'd8, 1'b1, 2'b10},
      '{64'd5, 64'd1, 1'b1, 2'b10},
      // primes, composites and strong pseudoprimes
      '{64'd5, 64'd2, 1'b0, 2'b00},
      '{64'd2047, 64'd2, 1'b0, 2'b00},
      '{64'd561, 64'd2, 1'b0, 2'b00},
      '{64'd9, 64'd8, 1'b0, 2'b00},
      // even candidates above four
      '{64'd6, 64'd5, 1'b0, 2'b00},
      '{ALL_ONES - 64'd1, ALL_ONES, 1'b0, 2'b00},
      // large candidates, most at the top of the range
      '{64'hFFFF_FFFF_FFFF_FFC5, 64'd3, 1'b0, 2'b00},
      '{64'hFFFF_FFFF_FFFF_FFC5, ALL_ONES, 1'b0, 2'b00},
      '{ALL_ONES, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 2'b00},
      '{64'h8000_0000_0000_0001, 64'h5555_5555_5555_5555, 1'b0, 2'b00},
      '{64'd1_000_000_007, 64'd2, 1'b0, 2'b00}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      ans = rows[i].has_answer ? rows[i].answer
                               : predict_round(rows[i].cand, rows[i].wit);
      send_beat(rows[i].cand, rows[i].wit, ans);
    end

    // Pause until every outstanding result has come back.
    in_valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);

    for (int k = 0; k < NUM_RANDOM; k++) begin
      if (k == NUM_RANDOM - 15) calm_tail = 1'b1;
      pick = $urandom_range(0, 5);
      case (pick)
        0: cand = 64'($urandom_range(0, 64));
        1: cand = rand64() | 64'd1;
        2: begin
          // product of two small odd numbers: often composite
          p = 64'($urandom() | 1);
          q = 64'($urandom() | 1);
          cand = p * q;
        end
        3: cand = ALL_ONES - 64'($urandom_range(0, 200));
        4: cand = 64'($urandom() | 1);
        default: cand = rand64();
      endcase
      wit = ($urandom_range(0, 4) == 0) ? rand64()
          : ((cand > 64'd4) ? 64'd2 + (rand64() % (cand - 64'd3)) : rand64());
      send_beat(cand, wit, predict_round(cand, wit));
    end
    in_valid_i <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    wait_cycles = 200;
    repeat (wait_cycles) @(posedge clk_i);
    if (error_count == 0 && verdict_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/mrr_pkg.sv
rtl/mrr_mulmod.sv
rtl/miller_rabin_round.sv
test/miller_rabin_round_tb.sv
